// ===== hdl/mssp_pkg.sv =====
// mssp_pkg: item types, defaults and the multiplexer order table for the
// multichannel sensor scan peak-to-peak block. no dependencies.
`timescale 1ns / 1ps

package mssp_pkg;

    localparam int DEF_CHANNELS            = 12;
    localparam int DEF_SAMPLES_PER_CHANNEL = 8;

    localparam int SAMPLE_W = 8;
    localparam int CHAN_W   = 4;
    localparam int MUX_W    = 4;
    localparam int ORDER_DEPTH = 12;

    localparam logic [MUX_W-1:0] MUX_LOW_MASK  = 4'h7;
    localparam logic [MUX_W-1:0] MUX_HIGH_MASK = 4'h8;
    localparam logic [MUX_W-1:0] MUX_CODE_MASK = 4'hf;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   channel;
    } req_item_t;

    typedef struct packed {
        logic [MUX_W-1:0]    mux_select;
        logic [SAMPLE_W-1:0] peak_to_peak;
        logic [SAMPLE_W-1:0] peak;
    } res_item_t;

    typedef logic [MUX_W-1:0] mux_order_t [ORDER_DEPTH];

    localparam mux_order_t MUX_ORDER = '{
        4'd0, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10, 4'd11, 4'd12, 4'd13, 4'd9
    };

    // low mux bits and high mux bit of the code for one scan channel
    function automatic logic [MUX_W-1:0] mux_code(input logic [CHAN_W-1:0] ch);
        logic [MUX_W-1:0] code;
        code = MUX_ORDER[ch];
        return ((code & MUX_LOW_MASK) | (code & MUX_HIGH_MASK)) & MUX_CODE_MASK;
    endfunction

endpackage

// ===== hdl/mssp_stream_if.sv =====
// mssp_stream_if: valid/ready channel carrying one item of type item_t.
// depends on nothing; item types come from mssp_pkg at the point of use.
`timescale 1ns / 1ps

interface mssp_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ===== hdl/multichannel_sensor_scan_peak_to_peak.sv =====
// multichannel_sensor_scan_peak_to_peak: scan store of sensor samples with
// per-channel peak and peak-to-peak query. depends on mssp_pkg, mssp_stream_if.
//
//   port     dir   payload                              role
//   request  sink  op, sample, channel (mssp_pkg)       sample write or channel query
//   result   src   mux_select, peak_to_peak, peak       one result per request
//
// a sample writes to the store at the scan position, then loads the result.
// a query reads the channel's slots through the single read port of the store
// (one slot per cycle, registered read); an out-of-range channel goes straight to result load.
// reset clears the scan position and fill mark; slots not yet written read as zero.
// a result waiting in the output register does not block the next request transfer;
// a finished item waits in its last state until the output register is free.
`timescale 1ns / 1ps

module multichannel_sensor_scan_peak_to_peak #(
    parameter int CHANNELS            = mssp_pkg::DEF_CHANNELS,
    parameter int SAMPLES_PER_CHANNEL = mssp_pkg::DEF_SAMPLES_PER_CHANNEL
) (
    input  logic          clk,
    input  logic          rst_n,
    mssp_stream_if.sink   request,
    mssp_stream_if.source result
);
    import mssp_pkg::*;

    localparam int DEPTH  = CHANNELS * SAMPLES_PER_CHANNEL;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(SAMPLES_PER_CHANNEL);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLES_PER_CHANNEL - 1);
    localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(CHANNELS - 1);
    localparam logic [ADDR_W-1:0] LAST_POS  = ADDR_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_HOLD = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // scan position, kept both linear and split into channel and slot
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                wrapped_reg, wrapped_next;

    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [SLOT_W-1:0]   cnt_reg, cnt_next;
    logic                rd_valid_reg;
    logic                rd_first_reg;
    logic                rd_ok_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [SAMPLE_W-1:0] hi_reg, hi_next;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;

    logic                out_valid_reg, out_valid_next;
    res_item_t           out_data_reg, out_data_next;

    logic [SAMPLE_W-1:0] store_mem [DEPTH];

    logic                accept;
    logic                wr_en;
    logic                rd_en;
    logic                load_out;
    logic [SAMPLE_W-1:0] rd_value;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign wr_en         = accept && (request.data.op == OP_SAMPLE);
    assign rd_en         = (state_reg == S_SCAN);
    assign load_out      = (state_reg == S_HOLD) && (!out_valid_reg || result.ready);
    assign rd_value      = rd_ok_reg ? rd_data_reg : '0;

    assign result.valid  = out_valid_reg;
    assign result.data   = out_data_reg;

    // sample store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[pos_reg] <= request.data.sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr_reg];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        slot_next      = slot_reg;
        wrapped_next   = wrapped_reg;
        rd_addr_next   = rd_addr_reg;
        cnt_next       = cnt_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        // fold the sample that came back from the store
        if (rd_valid_reg)
        begin
            if (rd_first_reg)
            begin
                hi_next = rd_value;
                lo_next = rd_value;
            end
            else
            begin
                if (rd_value > hi_reg)
                begin
                    hi_next = rd_value;
                end
                if (rd_value < lo_reg)
                begin
                    lo_next = rd_value;
                end
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    hi_next = '0;
                    lo_next = '0;
                    if (request.data.op == OP_SAMPLE)
                    begin
                        state_next = S_HOLD;
                        if (pos_reg == LAST_POS)
                        begin
                            pos_next     = '0;
                            wrapped_next = 1'b1;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                        if (slot_reg == LAST_SLOT)
                        begin
                            slot_next = '0;
                            ch_next   = (ch_reg == LAST_CH) ? '0 : ch_reg + 1'b1;
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                    else if (int'(request.data.channel) < CHANNELS)
                    begin
                        state_next   = S_SCAN;
                        rd_addr_next = ADDR_W'(int'(request.data.channel) * SAMPLES_PER_CHANNEL);
                        cnt_next     = '0;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_SCAN:
            begin
                rd_addr_next = rd_addr_reg + 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (load_out)
                begin
                    state_next                 = S_IDLE;
                    out_valid_next             = 1'b1;
                    out_data_next.mux_select   = mux_code(CHAN_W'(ch_reg));
                    out_data_next.peak_to_peak = hi_reg - lo_reg;
                    out_data_next.peak         = hi_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            ch_reg        <= '0;
            slot_reg      <= '0;
            wrapped_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rd_first_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ch_reg        <= ch_next;
            slot_reg      <= slot_next;
            wrapped_reg   <= wrapped_next;
            rd_valid_reg  <= rd_en;
            rd_first_reg  <= rd_en && (cnt_reg == '0);
            out_valid_reg <= out_valid_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        // slots beyond the fill mark have never been written and read as zero
        rd_ok_reg    <= wrapped_reg || (rd_addr_reg < pos_reg);
    end

    // scan position stays inside the store
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < DEPTH)
        else $error("scan position beyond store");

    // linear position agrees with channel and slot
    a_pos_split: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) == int'(ch_reg) * SAMPLES_PER_CHANNEL + int'(slot_reg))
        else $error("scan position and channel/slot disagree");

    // running maximum never falls below running minimum
    a_hi_lo: assert property (@(posedge clk) disable iff (!rst_n)
        hi_reg >= lo_reg)
        else $error("peak below minimum");

    // all reads have been folded in before a result is formed
    a_hold_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> !rd_valid_reg && !rd_en)
        else $error("read still in flight while result is formed");

    // a query of a valid channel starts the read sweep
    a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (request.data.op == OP_QUERY) && (int'(request.data.channel) < CHANNELS)
        |=> (state_reg == S_SCAN))
        else $error("query did not start the read sweep");

endmodule

// ===== sim/multichannel_sensor_scan_peak_to_peak_tb.sv =====
// multichannel_sensor_scan_peak_to_peak_tb: self-checking bench for the sensor scan
// peak-to-peak block, with its own scan store model and random handshake idling.
// depends on mssp_pkg, mssp_stream_if and multichannel_sensor_scan_peak_to_peak.
`timescale 1ns / 1ps

module multichannel_sensor_scan_peak_to_peak_tb;

    import mssp_pkg::*;

    localparam int NUM_CHANNELS = 12;
    localparam int SLOTS_PER_CH = 8;
    localparam int SLOT_TOTAL   = NUM_CHANNELS * SLOTS_PER_CH;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 20;

    // multiplexer code for each scan channel, in scan order
    localparam logic [MUX_W-1:0] CHAN_CODE [NUM_CHANNELS] = '{
        4'd0, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10, 4'd11, 4'd12, 4'd13, 4'd9
    };

    logic clk;
    logic rst_n;

    mssp_stream_if #(.item_t(req_item_t)) request_ch ();
    mssp_stream_if #(.item_t(res_item_t)) result_ch ();

    multichannel_sensor_scan_peak_to_peak DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    req_item_t pending_items[$];
    res_item_t expected_results[$];

    logic [SAMPLE_W-1:0] slot_mem [SLOT_TOTAL];
    int scan_pos;

    int error_count;
    int idle_cycles;
    int send_gap;
    int recv_gap;
    int hold_left;
    bit long_hold_go;
    bit long_hold_done;
    bit no_idle;

    always #5 clk = ~clk;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // updates the scan store and position, returns the result the block should give
    function automatic res_item_t scan_predict(input req_item_t item);
        res_item_t r;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] v;
        int base;
        r = '0;
        if (item.op == OP_SAMPLE)
        begin
            slot_mem[scan_pos] = item.sample;
            scan_pos = (scan_pos == SLOT_TOTAL - 1) ? 0 : scan_pos + 1;
        end
        else if (item.channel < NUM_CHANNELS)
        begin
            base = item.channel * SLOTS_PER_CH;
            hi = slot_mem[base];
            lo = hi;
            for (int i = 1; i < SLOTS_PER_CH; i++)
            begin
                v = slot_mem[base + i];
                if (v > hi)
                    hi = v;
                if (v < lo)
                    lo = v;
            end
            r.peak = hi;
            r.peak_to_peak = hi - lo;
        end
        r.mux_select = CHAN_CODE[scan_pos / SLOTS_PER_CH];
        return r;
    endfunction

    function automatic req_item_t make_item(input op_t op, input int sample, input int channel);
        req_item_t item;
        item.op = op;
        item.sample = sample[SAMPLE_W-1:0];
        item.channel = channel[CHAN_W-1:0];
        return item;
    endfunction

    function automatic req_item_t random_item(input int query_pct);
        req_item_t item;
        int r;
        item.op = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_SAMPLE;
        r = $urandom_range(0, 99);
        if (r < 5)
            item.sample = '0;
        else if (r < 10)
            item.sample = '1;
        else
            item.sample = SAMPLE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85)
            item.channel = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
        else
            item.channel = CHAN_W'($urandom_range(NUM_CHANNELS, 15));
        return item;
    endfunction

    task automatic queue_random(input int count, input int query_pct);
        for (int i = 0; i < count; i++)
            pending_items.push_back(random_item(query_pct));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || request_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_ch.valid <= 1'b0;
            request_ch.data  <= '0;
            send_gap = 0;
        end
        else if (!request_ch.valid || request_ch.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                request_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                request_ch.data  <= pending_items.pop_front();
                request_ch.valid <= 1'b1;
                send_gap = no_idle ? 0 : draw_gap();
            end
            else
                request_ch.valid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (long_hold_go && !long_hold_done)
            begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                recv_gap = no_idle ? 0 : draw_gap();
            end
        end
    end

    // result check, then prediction for any request transfer on this edge
    always @(posedge clk)
    begin
        res_item_t want;
        res_item_t got;
        if (!rst_n)
        begin
            error_count = 0;
            scan_pos = 0;
            for (int i = 0; i < SLOT_TOTAL; i++)
                slot_mem[i] = '0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: %p", got);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.mux_select !== want.mux_select)
                    begin
                        $error("mux_select: expected %0d, got %0d",
                               want.mux_select, got.mux_select);
                        error_count++;
                    end
                    if (got.peak_to_peak !== want.peak_to_peak)
                    begin
                        $error("peak_to_peak: expected %0d, got %0d",
                               want.peak_to_peak, got.peak_to_peak);
                        error_count++;
                    end
                    if (got.peak !== want.peak)
                    begin
                        $error("peak: expected %0d, got %0d", want.peak, got.peak);
                        error_count++;
                    end
                end
            end
            if (request_ch.valid && request_ch.ready)
                expected_results.push_back(scan_predict(request_ch.data));
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("multichannel_sensor_scan_peak_to_peak_tb: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        long_hold_go = 1'b0;
        no_idle = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // queries before any sample, in range and out of range
        pending_items.push_back(make_item(OP_QUERY, 8'hff, 0));
        pending_items.push_back(make_item(OP_QUERY, 8'h00, 11));
        pending_items.push_back(make_item(OP_QUERY, 8'h5a, 12));
        pending_items.push_back(make_item(OP_QUERY, 8'ha5, 15));
        // fill channel 0 with extremes, the last sample moves the scan to channel 1
        pending_items.push_back(make_item(OP_SAMPLE, 0, 15));
        pending_items.push_back(make_item(OP_SAMPLE, 255, 0));
        pending_items.push_back(make_item(OP_SAMPLE, 128, 7));
        pending_items.push_back(make_item(OP_SAMPLE, 1, 8));
        pending_items.push_back(make_item(OP_SAMPLE, 254, 3));
        pending_items.push_back(make_item(OP_SAMPLE, 127, 12));
        pending_items.push_back(make_item(OP_SAMPLE, 85, 5));
        pending_items.push_back(make_item(OP_SAMPLE, 170, 10));
        pending_items.push_back(make_item(OP_QUERY, 0, 0));
        pending_items.push_back(make_item(OP_QUERY, 255, 1));
        // partly filled channel: unwritten slots still read as zero
        pending_items.push_back(make_item(OP_SAMPLE, 200, 1));
        pending_items.push_back(make_item(OP_SAMPLE, 200, 2));
        pending_items.push_back(make_item(OP_SAMPLE, 200, 4));
        pending_items.push_back(make_item(OP_QUERY, 0, 1));
        pending_items.push_back(make_item(OP_QUERY, 0, 13));
        pending_items.push_back(make_item(OP_QUERY, 0, 14));
        wait_drained();

        // receiver holds off while the sender keeps offering
        queue_random(700, 30);
        long_hold_go = 1'b1;
        wait_drained();

        // back-to-back stretch with no idling on either side
        no_idle = 1'b1;
        queue_random(400, 25);
        while (pending_items.size() != 0)
            @(posedge clk);
        no_idle = 1'b0;

        queue_random(730, 35);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("multichannel_sensor_scan_peak_to_peak_tb: PASS");
        else
            $display("multichannel_sensor_scan_peak_to_peak_tb: FAIL");
        $finish;
    end

endmodule
